/* hdl/pvt_pkg.sv */
package pvt_pkg;

  localparam int unsigned TRIG_W     = 18;
  localparam int unsigned MAT_W      = 27;
  localparam int unsigned DIFF_W     = 33;
  localparam int unsigned ROT_W      = 38;
  localparam int unsigned QUO_W      = 34;
  localparam int unsigned PROJ_SHIFT = 15;
  localparam int unsigned FRONT_ST   = 7;
  localparam int unsigned DIV_ST     = QUO_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                         64'd110, 64'd156, 64'd210, 64'd272};
  localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                         64'd90, 64'd132, 64'd182, 64'd240};

  localparam logic [31:0] SCR_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] SCR_MIN  = 32'h8000_0000;
  localparam logic [31:0] SCR_HALF = 32'h0000_8000;
  localparam logic [31:0] NEG_ONE  = 32'hFFFF_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_ROLL,
    REG_PITCH,
    REG_YAW,
    REG_NEAR,
    REG_SCALE
  } reg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef logic [8:0][MAT_W-1:0] mat_t;

  typedef struct packed {
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
    logic [7:0]         roll_index;
    logic [7:0]         pitch_index;
    logic [7:0]         yaw_index;
    logic [30:0]        near_plane;
    logic [30:0]        depth_scale;
  } cfg_t;

  typedef struct packed {
    logic        behind;
    logic [31:0] nd;
  } side_t;

  function automatic trig_t rom_entry(input logic [63:0] turn);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    logic signed [63:0] so;
    logic signed [63:0] co;
    trig_t              e;
    a  = ({34'd0, turn[29:0]} * HALF_PI_Q30) >> 30;
    a2 = (a * a) >> 30;
    ts = a;
    tc = 64'd1 << 30;
    ss = $signed(a);
    cs = $signed(tc);
    for (int k = 0; k < 8; k++) begin
      ts = ((ts * a2) >> 30) / SIN_DIV[k];
      tc = ((tc * a2) >> 30) / COS_DIV[k];
      if (k[0] == 1'b0) begin
        ss = ss - $signed(ts);
        cs = cs - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        cs = cs + $signed(tc);
      end
    end
    if (ss < 0) ss = 0;
    else if (ss > 64'sd1073741824) ss = 64'sd1073741824;
    if (cs < 0) cs = 0;
    else if (cs > 64'sd1073741824) cs = 64'sd1073741824;
    case (turn[31:30])
      2'd0: begin so = ss;  co = cs;  end
      2'd1: begin so = cs;  co = -ss; end
      2'd2: begin so = -ss; co = -cs; end
      default: begin so = -cs; co = ss; end
    endcase
    e.s = TRIG_W'((so + 64'sd8192) >>> 14);
    e.c = TRIG_W'((co + 64'sd8192) >>> 14);
    return e;
  endfunction

endpackage

/* hdl/pvt_matrix.sv */
module pvt_matrix #(
  parameter int unsigned ANGLE_STEPS = 256
) (
  input  logic          clk,
  input  logic [7:0]    roll_index,
  input  logic [7:0]    pitch_index,
  input  logic [7:0]    yaw_index,
  output pvt_pkg::mat_t mat
);
  import pvt_pkg::*;

  localparam int unsigned IDX_W    = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
  localparam int unsigned IDX_SPAN = 256;
  localparam logic signed [55:0] RND8  = 56'sd128;
  localparam logic signed [55:0] RND24 = 56'sd8388608;

  logic [IDX_W-1:0] wrap_tab [IDX_SPAN];
  trig_t            rom [ANGLE_STEPS];

  for (genvar gi = 0; gi < IDX_SPAN; gi++) begin : g_wrap
    localparam int unsigned WV = gi % ANGLE_STEPS;
    assign wrap_tab[gi] = IDX_W'(WV);
  end

  for (genvar gi = 0; gi < ANGLE_STEPS; gi++) begin : g_rom
    localparam logic [63:0] TURN = (64'(gi) << 32) / ANGLE_STEPS;
    localparam trig_t ENTRY = rom_entry(TURN);
    assign rom[gi] = ENTRY;
  end

  trig_t tx_r, ty_r, tz_r;

  logic signed [35:0] cycz_r, cysz_r, cxsz_r, cxcz_r, sxcy_r, cxcy_r;
  logic signed [35:0] sxsz_r, sxcz_r, sxsy_r, cxsy_r;
  logic signed [TRIG_W-1:0] sy2_r, sz2_r, cz2_r;

  logic signed [35:0] cycz3_r, cysz3_r, cxsz3_r, cxcz3_r, sxcy3_r, cxcy3_r;
  logic signed [35:0] sxsz3_r, sxcz3_r;
  logic signed [TRIG_W-1:0] sy3_r;
  logic signed [55:0] sxsycz_r, sxsysz_r, cxsycz_r, cxsysz_r;

  mat_t mat_r;

  always_ff @(posedge clk) begin
    tx_r <= rom[wrap_tab[roll_index]];
    ty_r <= rom[wrap_tab[pitch_index]];
    tz_r <= rom[wrap_tab[yaw_index]];

    cycz_r <= 36'(ty_r.c) * 36'(tz_r.c);
    cysz_r <= 36'(ty_r.c) * 36'(tz_r.s);
    cxsz_r <= 36'(tx_r.c) * 36'(tz_r.s);
    cxcz_r <= 36'(tx_r.c) * 36'(tz_r.c);
    sxcy_r <= 36'(tx_r.s) * 36'(ty_r.c);
    cxcy_r <= 36'(tx_r.c) * 36'(ty_r.c);
    sxsz_r <= 36'(tx_r.s) * 36'(tz_r.s);
    sxcz_r <= 36'(tx_r.s) * 36'(tz_r.c);
    sxsy_r <= 36'(tx_r.s) * 36'(ty_r.s);
    cxsy_r <= 36'(tx_r.c) * 36'(ty_r.s);
    sy2_r  <= ty_r.s;
    sz2_r  <= tz_r.s;
    cz2_r  <= tz_r.c;

    sxsycz_r <= 56'(sxsy_r) * 56'(cz2_r);
    sxsysz_r <= 56'(sxsy_r) * 56'(sz2_r);
    cxsycz_r <= 56'(cxsy_r) * 56'(cz2_r);
    cxsysz_r <= 56'(cxsy_r) * 56'(sz2_r);
    cycz3_r  <= cycz_r;
    cysz3_r  <= cysz_r;
    cxsz3_r  <= cxsz_r;
    cxcz3_r  <= cxcz_r;
    sxcy3_r  <= sxcy_r;
    cxcy3_r  <= cxcy_r;
    sxsz3_r  <= sxsz_r;
    sxcz3_r  <= sxcz_r;
    sy3_r    <= sy2_r;

    mat_r[0] <= MAT_W'((56'(cycz3_r) + RND8) >>> 8);
    mat_r[1] <= MAT_W'((RND8 - 56'(cysz3_r)) >>> 8);
    mat_r[2] <= MAT_W'(56'(sy3_r) <<< 8);
    mat_r[3] <= MAT_W'(((56'(cxsz3_r) <<< 16) + sxsycz_r + RND24) >>> 24);
    mat_r[4] <= MAT_W'(((56'(cxcz3_r) <<< 16) - sxsysz_r + RND24) >>> 24);
    mat_r[5] <= MAT_W'((RND8 - 56'(sxcy3_r)) >>> 8);
    mat_r[6] <= MAT_W'(((56'(sxsz3_r) <<< 16) - cxsycz_r + RND24) >>> 24);
    mat_r[7] <= MAT_W'(((56'(sxcz3_r) <<< 16) + cxsysz_r + RND24) >>> 24);
    mat_r[8] <= MAT_W'((56'(cxcy3_r) + RND8) >>> 8);
  end

  assign mat = mat_r;

endmodule

/* hdl/pvt_front.sv */
module pvt_front (
  input  logic                                 clk,
  input  logic [pvt_pkg::FRONT_ST-1:0]         en,
  input  logic signed [31:0]                   point_x,
  input  logic signed [31:0]                   point_y,
  input  logic signed [31:0]                   point_z,
  input  pvt_pkg::cfg_t                        cfg,
  input  pvt_pkg::mat_t                        mat,
  output logic signed [pvt_pkg::ROT_W-1:0]     rot_x,
  output logic signed [pvt_pkg::ROT_W-1:0]     rot_y,
  output logic signed [pvt_pkg::ROT_W-1:0]     rot_z,
  output pvt_pkg::side_t                       side
);
  import pvt_pkg::*;

  localparam logic signed [61:0] RND24 = 62'sd8388608;

  logic signed [DIFF_W-1:0] px_e, near_e, near_diff;
  logic signed [DIFF_W-1:0] d_c [3];
  logic signed [MAT_W-1:0]  m_s [9];

  logic signed [DIFF_W-1:0] d0_r [3];
  logic signed [DIFF_W-1:0] d1_r [3];
  logic signed [DIFF_W-1:0] d2_r [3];
  logic signed [DIFF_W-1:0] d3_r [3];
  logic [30:0]              pd0_r;
  logic [61:0]              dp1_r;
  logic                     behind0_r, behind1_r;
  side_t                    side2_r, side3_r, side4_r, side5_r, side6_r;
  logic signed [42:0]       ph4_r [9];
  logic signed [44:0]       pl4_r [9];
  logic signed [59:0]       t5_r [9];
  logic signed [ROT_W-1:0]  r6_r [3];

  always_comb begin
    px_e      = DIFF_W'(point_x);
    near_e    = $signed({2'b00, cfg.near_plane});
    near_diff = px_e - near_e;
    d_c[0]    = DIFF_W'(point_x) - DIFF_W'(cfg.camera_x);
    d_c[1]    = DIFF_W'(point_y) - DIFF_W'(cfg.camera_y);
    d_c[2]    = DIFF_W'(point_z) - DIFF_W'(cfg.camera_z);
    for (int i = 0; i < 9; i++) begin
      m_s[i] = $signed(mat[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d0_r      <= d_c;
      pd0_r     <= near_diff[30:0];
      behind0_r <= px_e < near_e;
    end
    if (en[1]) begin
      d1_r      <= d0_r;
      dp1_r     <= 62'(pd0_r) * 62'(cfg.depth_scale);
      behind1_r <= behind0_r;
    end
    if (en[2]) begin
      d2_r           <= d1_r;
      side2_r.behind <= behind1_r;
      side2_r.nd     <= (dp1_r[61:47] != '0) ? SCR_MAX : {1'b0, dp1_r[46:16]};
    end
    if (en[3]) begin
      d3_r    <= d2_r;
      side3_r <= side2_r;
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph4_r[3*i+j] <= 43'(m_s[3*i+j]) * 43'($signed(d3_r[j][32:17]));
          pl4_r[3*i+j] <= 45'(m_s[3*i+j]) * 45'($signed({1'b0, d3_r[j][16:0]}));
        end
      end
      side4_r <= side3_r;
    end
    if (en[5]) begin
      for (int i = 0; i < 9; i++) begin
        t5_r[i] <= (60'(ph4_r[i]) <<< 17) + 60'(pl4_r[i]);
      end
      side5_r <= side4_r;
    end
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        r6_r[i] <= ROT_W'((62'(t5_r[3*i]) + 62'(t5_r[3*i+1]) + 62'(t5_r[3*i+2])
                           + RND24) >>> 24);
      end
      side6_r <= side5_r;
    end
  end

  assign rot_x = r6_r[0];
  assign rot_y = r6_r[1];
  assign rot_z = r6_r[2];
  assign side  = side6_r;

endmodule

/* hdl/pvt_div.sv */
module pvt_div (
  input  logic                              clk,
  input  logic [pvt_pkg::DIV_ST-1:0]        en,
  input  logic signed [pvt_pkg::ROT_W-1:0]  lat,
  input  logic signed [pvt_pkg::ROT_W-1:0]  dep,
  output logic [31:0]                       screen
);
  import pvt_pkg::*;

  localparam int unsigned LOW_W = QUO_W - PROJ_SHIFT;

  typedef struct packed {
    logic neg;
    logic zero;
    logic lat_neg;
    logic lat_nz;
    logic ovf;
  } div_flags_t;

  logic [ROT_W-1:0] alat_c, adep_c;
  logic [ROT_W-1:0] alat0_r, adep0_r;
  div_flags_t       fl0_r;
  logic [ROT_W-1:0] hi_c;

  logic [ROT_W-1:0] p_r  [QUO_W];
  logic [ROT_W-1:0] d_r  [QUO_W];
  logic [QUO_W-1:0] nq_r [QUO_W+1];
  div_flags_t       fl_r [QUO_W+1];

  logic [QUO_W-1:0]   q_c;
  logic signed [35:0] qs_c, sum_c;

  assign alat_c = lat[ROT_W-1] ? ROT_W'(-lat) : ROT_W'(lat);
  assign adep_c = dep[ROT_W-1] ? ROT_W'(-dep) : ROT_W'(dep);
  assign hi_c   = {{LOW_W{1'b0}}, alat0_r[ROT_W-1:LOW_W]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      alat0_r       <= alat_c;
      adep0_r       <= adep_c;
      fl0_r.neg     <= lat[ROT_W-1] ^ dep[ROT_W-1];
      fl0_r.zero    <= (dep == '0);
      fl0_r.lat_neg <= lat[ROT_W-1];
      fl0_r.lat_nz  <= (lat != '0);
      fl0_r.ovf     <= {{LOW_W{1'b0}}, alat_c[ROT_W-1:LOW_W]} >= adep_c;
    end
    if (en[1]) begin
      p_r[0]      <= hi_c;
      d_r[0]      <= adep0_r;
      nq_r[0]     <= {alat0_r[LOW_W-1:0], {PROJ_SHIFT{1'b0}}};
      fl_r[0]     <= fl0_r;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [ROT_W:0] pw, dif;
    logic           ge;
    assign pw  = {p_r[k-1], nq_r[k-1][QUO_W-1]};
    assign ge  = pw >= {1'b0, d_r[k-1]};
    assign dif = pw - {1'b0, d_r[k-1]};
    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        nq_r[k] <= {nq_r[k-1][QUO_W-2:0], ge};
        fl_r[k] <= fl_r[k-1];
      end
    end
    if (k < QUO_W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k+1]) begin
          p_r[k] <= ge ? dif[ROT_W-1:0] : pw[ROT_W-1:0];
          d_r[k] <= d_r[k-1];
        end
      end
    end
  end

  always_comb begin
    q_c   = fl_r[QUO_W].ovf ? '1 : nq_r[QUO_W];
    qs_c  = $signed({2'b00, q_c});
    if (fl_r[QUO_W].neg) qs_c = -qs_c;
    sum_c = qs_c + 36'sd32768;
    if (fl_r[QUO_W].zero) begin
      if (!fl_r[QUO_W].lat_nz) screen = SCR_HALF;
      else if (fl_r[QUO_W].lat_neg) screen = SCR_MIN;
      else screen = SCR_MAX;
    end else if (sum_c > 36'sd2147483647) begin
      screen = SCR_MAX;
    end else if (sum_c < -36'sd2147483648) begin
      screen = SCR_MIN;
    end else begin
      screen = sum_c[31:0];
    end
  end

endmodule

/* hdl/perspective_vertex_transform.sv */
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/tready     in_tdata: point_x, point_y, point_z
// out_     out  out_tvalid/tready    out_tdata: screen_u, screen_v, norm_depth;
//                                    out_tuser: behind_near
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One point per cycle while out_tready does not stall the output.
// The 34-step restoring divider sits behind the rotation pipeline.
// Each stage holds its own valid bit and advances when the next one is empty or
// moving, so bubbles close up while the output stalls.
// Reset restores the register defaults; the rotation matrix follows a register
// write before any request taken after that write reaches the rotation.
module perspective_vertex_transform #(
  parameter int unsigned ANGLE_STEPS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [95:0]                    in_tdata,   // point_x, point_y, point_z
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [95:0]                    out_tdata,  // screen_u, screen_v, norm_depth
  output logic                           out_tuser,  // behind_near
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import pvt_pkg::*;

  localparam int unsigned NS = FRONT_ST + DIV_ST + 1;

  cfg_t               cfg_r;
  mat_t               mat;
  logic [NS-1:0]      v_r;
  logic [NS:0]        en;
  logic signed [ROT_W-1:0] rot_x, rot_y, rot_z;
  side_t              front_side;
  side_t              side_r [DIV_ST];
  logic [31:0]        scr_u, scr_v;
  logic [31:0]        su_r, sv_r, nd_r;
  logic               behind_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.camera_x    <= '0;
      cfg_r.camera_y    <= '0;
      cfg_r.camera_z    <= '0;
      cfg_r.roll_index  <= '0;
      cfg_r.pitch_index <= '0;
      cfg_r.yaw_index   <= '0;
      cfg_r.near_plane  <= 31'd6554;
      cfg_r.depth_scale <= 31'd656;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CAMERA_X: cfg_r.camera_x    <= $signed(cfg_data);
        REG_CAMERA_Y: cfg_r.camera_y    <= $signed(cfg_data);
        REG_CAMERA_Z: cfg_r.camera_z    <= $signed(cfg_data);
        REG_ROLL:     cfg_r.roll_index  <= cfg_data[7:0];
        REG_PITCH:    cfg_r.pitch_index <= cfg_data[7:0];
        REG_YAW:      cfg_r.yaw_index   <= cfg_data[7:0];
        REG_NEAR:     cfg_r.near_plane  <= cfg_data[30:0];
        REG_SCALE:    cfg_r.depth_scale <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NS] = out_tready;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  pvt_matrix #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_matrix (
    .clk         (clk),
    .roll_index  (cfg_r.roll_index),
    .pitch_index (cfg_r.pitch_index),
    .yaw_index   (cfg_r.yaw_index),
    .mat         (mat)
  );

  pvt_front u_front (
    .clk     (clk),
    .en      (en[FRONT_ST-1:0]),
    .point_x ($signed(in_tdata[31:0])),
    .point_y ($signed(in_tdata[63:32])),
    .point_z ($signed(in_tdata[95:64])),
    .cfg     (cfg_r),
    .mat     (mat),
    .rot_x   (rot_x),
    .rot_y   (rot_y),
    .rot_z   (rot_z),
    .side    (front_side)
  );

  pvt_div u_div_u (
    .clk    (clk),
    .en     (en[FRONT_ST+DIV_ST-1:FRONT_ST]),
    .lat    (rot_y),
    .dep    (rot_x),
    .screen (scr_u)
  );

  pvt_div u_div_v (
    .clk    (clk),
    .en     (en[FRONT_ST+DIV_ST-1:FRONT_ST]),
    .lat    (rot_z),
    .dep    (rot_x),
    .screen (scr_v)
  );

  always_ff @(posedge clk) begin
    if (en[FRONT_ST]) side_r[0] <= front_side;
    for (int k = 1; k < DIV_ST; k++) begin
      if (en[FRONT_ST+k]) side_r[k] <= side_r[k-1];
    end
    if (en[NS-1]) begin
      behind_r <= side_r[DIV_ST-1].behind;
      su_r     <= side_r[DIV_ST-1].behind ? NEG_ONE : scr_u;
      sv_r     <= side_r[DIV_ST-1].behind ? NEG_ONE : scr_v;
      nd_r     <= side_r[DIV_ST-1].behind ? NEG_ONE : side_r[DIV_ST-1].nd;
    end
  end

  assign out_tdata = {nd_r, sv_r, su_r};
  assign out_tuser = behind_r;

endmodule
